// File: rtl/core/address_range_map_allocator_defines.svh
// Assertion macros for the address range map allocator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ADDRESS_RANGE_MAP_ALLOCATOR_DEFINES_SVH
`define ADDRESS_RANGE_MAP_ALLOCATOR_DEFINES_SVH

// plain property, checked outside reset
`define ARMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define ARMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/arma_pkg.sv
// Shared types and constants for the address range map allocator.
// No dependencies.
`default_nettype none

package arma_pkg;

  localparam int unsigned ARMA_ENTRIES = 64;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
    logic [2:0]  kind;
  } entry_t;

  localparam entry_t ENTRY_RST = '{start: '0, len: '1, kind: '0};

  typedef enum logic [2:0] {
    C_NOP,
    C_ROT,
    C_WR,
    C_INS,
    C_REM
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   wdata;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVERLAP = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_FRAG    = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FSTART,
    S_FSCAN,
    S_FDEC1,
    S_FDEC2,
    S_FDEC3,
    S_FMRG,
    S_FREM,
    S_ASCAN,
    S_A1,
    S_A2,
    S_ADIV0,
    S_ADIV,
    S_AALN,
    S_AFIT1,
    S_AFIT2,
    S_AFIT3,
    S_AEND,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/address_range_map_allocator.sv
// Top level: sorted typed range table with first-fit allocation.
// Depends on arma_pkg, arma_cell, arma_rem and the defines header.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid_i/in_stall_o | req_type, range_addr/size/kind, align_step
//   out     | out       | out_valid_o/out_stall_i | status, alloc_addr
//
// A free rotates the cell row through one full turn to find its neighbours, decodes
// them and writes the row; a free that joins both neighbours adds a merge write and a
// removal, and a zero-size or out-of-range free goes straight to its result. An alloc
// scans the row; each entry of the kind tried gets an address check and, if that passes,
// a fit check, preceded by alignment (serial remainder) when align_step is set; a
// split-off leading fragment is then returned by a free. One transaction is in flight at a time.
// After reset cell 0 holds the whole space as kind none; no clearing pass.
// A result waits in the output register; no new transaction until it is taken.
`default_nettype none
`include "address_range_map_allocator_defines.svh"

module address_range_map_allocator import arma_pkg::*; #(
  parameter int unsigned ENTRIES = ARMA_ENTRIES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [63:0] range_addr_i,
  input  wire logic [63:0] range_size_i,
  input  wire logic [2:0]  range_kind_i,
  input  wire logic [31:0] align_step_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [63:0]      alloc_addr_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;

  entry_t    cell_q [ENTRIES];
  entry_t    head;
  cell_ctl_t cell_ctl;
  logic [IW-1:0] cell_idx;

  logic        req_q;
  logic [63:0] addr_q, size_q;
  logic [2:0]  kind_q;
  logic [31:0] align_q;
  logic        frag_q;
  status_e     stat_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] rot_q;

  entry_t      prev_q, next_q;
  logic        hasp_q, hasn_q;
  logic [CW-1:0] p_q;
  logic [63:0] dp_q, dn_q, psum_q, nsum_q;
  logic        ovl_q, mp_q, mn_q;

  logic [63:0] s_q, l_q, a_q, off_q, lms_q, lmo_q, ns_q, nl_q, res_q;
  logic        gt_q, szle_q, ovf_q, done_q, skip_q, fit_q;
  logic [IW-1:0] idx_q;

  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [63:0] out_addr_q;

  logic        div_start, rem_done;
  logic [31:0] rem;

  logic in_acc, last, head_ok, elig, a2_stop, free_trivial;
  logic [32:0] inc;
  logic [64:0] aln_sum;

  assign head         = cell_q[0];
  assign in_acc       = in_valid_i && !in_stall_o;
  assign last         = (rot_q == IW'(ENTRIES - 1));
  assign head_ok      = (CW'(rot_q) < cnt_q);
  assign elig         = head_ok && (head.kind == kind_q) && !done_q && !skip_q;
  assign a2_stop      = (addr_q != '0) && (gt_q || (l_q < off_q) || (szle_q && (off_q > lms_q)));
  assign free_trivial = (size_q == '0) || (size_q > ~addr_q);
  assign inc          = {1'b0, align_q} - {1'b0, rem};
  assign aln_sum      = {1'b0, a_q} + 65'(inc);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arma_cell #(.ENTRIES(ENTRIES), .IDX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .idx_i   (cell_idx),
      .left_i  (cell_q[(g + ENTRIES - 1) % ENTRIES]),
      .right_i (cell_q[(g + 1) % ENTRIES]),
      .q_o     (cell_q[g])
    );
  end

  arma_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (align_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = req_type_i ? S_ASCAN : S_FSTART;
      S_FSTART: state_d = free_trivial ? S_DONE : S_FSCAN;
      S_FSCAN:  if (last) state_d = S_FDEC1;
      S_FDEC1:  state_d = S_FDEC2;
      S_FDEC2:  state_d = S_FDEC3;
      S_FDEC3:  state_d = (!ovl_q && mp_q && mn_q) ? S_FMRG : S_DONE;
      S_FMRG:   state_d = S_FREM;
      S_FREM:   state_d = S_DONE;
      S_ASCAN: begin
        if (elig) state_d = S_A1;
        else if (last) state_d = S_AEND;
      end
      S_A1:     state_d = S_A2;
      S_A2: begin
        if (a2_stop) state_d = S_ASCAN;
        else if (align_q != '0) state_d = S_ADIV0;
        else state_d = S_AFIT1;
      end
      S_ADIV0:  state_d = S_ADIV;
      S_ADIV:   if (rem_done) state_d = S_AALN;
      S_AALN:   state_d = ((rem != '0) && aln_sum[64]) ? S_ASCAN : S_AFIT1;
      S_AFIT1:  state_d = S_AFIT2;
      S_AFIT2:  state_d = S_AFIT3;
      S_AFIT3:  state_d = S_ASCAN;
      S_AEND: begin
        if (fit_q && (off_q != '0)) state_d = S_FSTART;
        else state_d = S_DONE;
      end
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // cell row and divider control
  always_comb begin
    cell_ctl.op    = C_NOP;
    cell_ctl.wdata = '{start: addr_q, len: size_q, kind: kind_q};
    cell_idx       = p_q[IW-1:0];
    div_start      = 1'b0;
    unique case (state_q)
      S_FSCAN: cell_ctl.op = C_ROT;
      S_ASCAN: if (!elig) cell_ctl.op = C_ROT;
      S_FDEC3: begin
        if (!ovl_q) begin
          if (mp_q && !mn_q) begin
            cell_ctl.op    = C_WR;
            cell_idx       = IW'(p_q - CW'(1));
            cell_ctl.wdata = '{start: prev_q.start, len: psum_q, kind: kind_q};
          end else if (!mp_q && mn_q) begin
            cell_ctl.op    = C_WR;
            cell_ctl.wdata = '{start: addr_q, len: nsum_q, kind: kind_q};
          end else if (!mp_q && !mn_q && (cnt_q < CW'(ENTRIES))) begin
            cell_ctl.op = C_INS;
          end
        end
      end
      S_FMRG: begin
        cell_ctl.op    = C_WR;
        cell_idx       = IW'(p_q - CW'(1));
        cell_ctl.wdata = '{start: prev_q.start, len: psum_q, kind: kind_q};
      end
      S_FREM: cell_ctl.op = C_REM;
      S_AEND: begin
        cell_idx = idx_q;
        if (fit_q) begin
          cell_ctl.op    = (nl_q == '0) ? C_REM : C_WR;
          cell_ctl.wdata = '{start: ns_q, len: nl_q, kind: kind_q};
        end
      end
      S_ADIV0: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CW'(1);
      rot_q       <= '0;
      out_valid_q <= 1'b0;
      frag_q      <= 1'b0;
      done_q      <= 1'b0;
      skip_q      <= 1'b0;
      fit_q       <= 1'b0;
      hasp_q      <= 1'b0;
      hasn_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          frag_q <= 1'b0;
          done_q <= 1'b0;
          skip_q <= 1'b0;
          fit_q  <= 1'b0;
          rot_q  <= '0;
        end
        S_FSTART: begin
          hasp_q <= 1'b0;
          hasn_q <= 1'b0;
          rot_q  <= '0;
        end
        S_FSCAN: begin
          if (head_ok && (head.start <= addr_q)) hasp_q <= 1'b1;
          else if (head_ok && !hasn_q) hasn_q <= 1'b1;
          rot_q <= last ? '0 : rot_q + IW'(1);
        end
        S_FDEC3: begin
          if (!ovl_q) begin
            if (!mp_q && !mn_q && (cnt_q < CW'(ENTRIES))) cnt_q <= cnt_q + CW'(1);
          end
        end
        S_FREM: cnt_q <= cnt_q - CW'(1);
        S_ASCAN: begin
          if (!elig) begin
            skip_q <= 1'b0;
            rot_q  <= last ? '0 : rot_q + IW'(1);
          end
        end
        S_A2: begin
          if (a2_stop) begin
            skip_q <= 1'b1;
            if (gt_q || ((l_q >= off_q) && szle_q && (off_q > lms_q))) done_q <= 1'b1;
          end
        end
        S_AALN: if ((rem != '0) && aln_sum[64]) skip_q <= 1'b1;
        S_AFIT3: begin
          skip_q <= 1'b1;
          if (!(ovf_q || (lmo_q < size_q))) begin
            fit_q  <= 1'b1;
            done_q <= 1'b1;
          end
        end
        S_AEND: begin
          if (fit_q && (nl_q == '0)) cnt_q <= cnt_q - CW'(1);
          if (fit_q && (off_q != '0)) frag_q <= 1'b1;
        end
        S_DONE: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        req_q   <= req_type_i;
        addr_q  <= range_addr_i;
        size_q  <= range_size_i;
        kind_q  <= range_kind_i;
        align_q <= align_step_i;
        stat_q  <= ST_NOFIT;
      end
      S_FSTART: begin
        p_q <= cnt_q;
        if (size_q == '0) stat_q <= ST_OK;
        else if (size_q > ~addr_q) stat_q <= ST_OVERLAP;
      end
      S_FSCAN: begin
        if (head_ok && (head.start <= addr_q)) prev_q <= head;
        else if (head_ok && !hasn_q) begin
          next_q <= head;
          p_q    <= CW'(rot_q);
        end
      end
      S_FDEC1: begin
        dp_q <= addr_q - prev_q.start;
        dn_q <= next_q.start - addr_q;
      end
      S_FDEC2: begin
        ovl_q  <= (hasp_q && (dp_q < prev_q.len)) || (hasn_q && (size_q > dn_q));
        mp_q   <= hasp_q && (prev_q.kind == kind_q) && (dp_q == prev_q.len);
        mn_q   <= hasn_q && (next_q.kind == kind_q) && (dn_q == size_q);
        psum_q <= prev_q.len + size_q;
        nsum_q <= next_q.len + size_q;
      end
      S_FDEC3: begin
        if (ovl_q) stat_q <= ST_OVERLAP;
        else if (!mp_q && !mn_q && (cnt_q >= CW'(ENTRIES))) stat_q <= ST_FULL;
        else stat_q <= ST_OK;
        if (mp_q && mn_q) psum_q <= psum_q + next_q.len;
      end
      S_A1: begin
        s_q    <= head.start;
        l_q    <= head.len;
        off_q  <= addr_q - head.start;
        lms_q  <= head.len - size_q;
        gt_q   <= head.start > addr_q;
        szle_q <= size_q <= head.len;
      end
      S_A2: a_q <= (addr_q != '0) ? addr_q : s_q;
      S_AALN: if (rem != '0) a_q <= aln_sum[63:0];
      S_AFIT1: off_q <= a_q - s_q;
      S_AFIT2: begin
        lmo_q <= l_q - off_q;
        ovf_q <= off_q > l_q;
      end
      S_AFIT3: begin
        idx_q <= rot_q;
        ns_q  <= a_q + size_q;
        nl_q  <= lmo_q - size_q;
      end
      S_AEND: begin
        res_q <= a_q;
        if (fit_q) begin
          stat_q <= ST_OK;
          addr_q <= s_q;
          size_q <= off_q;
        end
      end
      S_DONE: begin
        if (frag_q) begin
          out_status_q <= (stat_q == ST_OK) ? ST_OK : ST_FRAG;
          out_addr_q   <= res_q;
        end else begin
          out_status_q <= stat_q;
          out_addr_q   <= (req_q && (stat_q == ST_OK)) ? res_q : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign alloc_addr_o = out_addr_q;

  `ARMA_ASSERT(a_cnt_range, cnt_q <= CW'(ENTRIES), "entry count out of range")
  `ARMA_ASSERT(a_scan_origin, (state_q != S_FDEC1) || (rot_q == '0), "row not back at origin")
  `ARMA_ASSERT(a_ins_room, (cell_ctl.op != C_INS) || (cnt_q < CW'(ENTRIES)), "insert into full row")
  `ARMA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE, "accept lost")

endmodule

`default_nettype wire

// File: rtl/core/arma_cell.sv
// One table entry of the allocator's cell row.
// Depends on arma_pkg; rotates, shifts and writes with its neighbours.
`default_nettype none

module arma_cell import arma_pkg::*; #(
  parameter int unsigned ENTRIES = ARMA_ENTRIES,
  parameter int unsigned IDX     = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cell_ctl_t                    ctl_i,
  input  wire logic [$clog2(ENTRIES)-1:0]   idx_i,
  input  wire entry_t                       left_i,
  input  wire entry_t                       right_i,
  output entry_t                            q_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    unique case (ctl_i.op)
      C_ROT: ent_d = right_i;
      C_WR: begin
        if (MY_IDX == idx_i) ent_d = ctl_i.wdata;
      end
      C_INS: begin
        if (MY_IDX > idx_i) ent_d = left_i;
        else if (MY_IDX == idx_i) ent_d = ctl_i.wdata;
      end
      C_REM: begin
        if (MY_IDX >= idx_i) ent_d = right_i;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ent_q <= ENTRY_RST;
    else ent_q <= ent_d;
  end

  assign q_o = ent_q;

endmodule

`default_nettype wire

// File: rtl/core/arma_rem.sv
// Bit-serial remainder unit: 64-bit dividend modulo 32-bit divisor.
// Depends on arma_pkg only for house style; one quotient bit per cycle.
`default_nettype none

module arma_rem import arma_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      rem_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], 1'b0};
      if (!diff[32]) rem_q <= diff[31:0];
      else rem_q <= trial[31:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
